// File: hdl/euc_pkg.sv
// ----------------------------------------------------------------------------
// euc_pkg: shared types, constants and helpers
// Status and kind codes, prefix tables and state bundles for the endpoint
// text classifier.
// ----------------------------------------------------------------------------
package euc_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF     = 1024;
  localparam int unsigned PIPE_NAME_CAPACITY_DEF = 128;
  localparam int unsigned PIPE_TAG_LEN           = 7;
  localparam int unsigned VSOCK_TAG_LEN          = 8;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7f;
  localparam logic [7:0] CHAR_QUEST = 8'h3f;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_AT    = 8'h40;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_RANGE     = 2'd2,
    ST_UNHANDLED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PIPE  = 2'd1,
    KIND_VSOCK = 2'd2
  } kind_t;

  // Running decimal field: value, first error, and whether any byte landed in it
  typedef struct packed {
    logic [31:0] value;
    status_t     err;
    logic        any;
  } acc_state_t;

  typedef struct packed {
    logic       pipe_ok;
    logic       vsock_ok;
    logic       name_bad;
    logic [1:0] colon_seen;
    acc_state_t cid;
    acc_state_t port;
  } scan_flags_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [31:0] cid;
    logic [31:0] port;
    logic [6:0]  pipe_name_len;
  } result_t;

  function automatic logic [7:0] pipe_tag_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h70; // p
      3'd1:    c = 8'h69; // i
      3'd2:    c = 8'h70; // p
      3'd3:    c = 8'h65; // e
      3'd4:    c = CHAR_COLON;
      3'd5:    c = 8'h2f;
      3'd6:    c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] vsock_tag_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h76; // v
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h6f; // o
      3'd3:    c = 8'h63; // c
      3'd4:    c = 8'h6b; // k
      3'd5:    c = CHAR_COLON;
      3'd6:    c = 8'h2f;
      default: c = 8'h2f;
    endcase
    return c;
  endfunction

  function automatic logic bad_name_byte(input logic [7:0] b);
    return (b <= CHAR_SPACE) || (b == CHAR_DEL) || (b == CHAR_QUEST) ||
           (b == CHAR_HASH) || (b == CHAR_AT);
  endfunction

endpackage

// File: hdl/euc_digit_acc.sv
// ----------------------------------------------------------------------------
// euc_digit_acc: decimal field accumulator
// Folds one ASCII digit per cycle into a 32-bit value with overflow and
// non-digit detection; the first error sticks until the field is cleared.
// ----------------------------------------------------------------------------
module euc_digit_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                take,
  input  logic [7:0]          text_byte,
  output euc_pkg::acc_state_t acc
);

  euc_pkg::acc_state_t acc_next;
  logic [35:0]         wide;
  logic [3:0]          digit;

  assign digit = 4'(text_byte - euc_pkg::CHAR_ZERO);
  // value * 10 + digit, with four guard bits to catch overflow
  assign wide  = {1'b0, acc.value, 3'b000} + {3'b000, acc.value, 1'b0} + {32'd0, digit};

  always_comb begin
    acc_next = acc;
    if (clear) begin
      acc_next.value = '0;
      acc_next.err   = euc_pkg::ST_OK;
      acc_next.any   = 1'b0;
    end else if (take) begin
      acc_next.any = 1'b1;
      if (acc.err == euc_pkg::ST_OK) begin
        if (text_byte < euc_pkg::CHAR_ZERO || text_byte > euc_pkg::CHAR_NINE) begin
          acc_next.err = euc_pkg::ST_INVALID;
        end else if (wide[35:32] != 4'd0) begin
          acc_next.err = euc_pkg::ST_RANGE;
        end else begin
          acc_next.value = wide[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc.value <= '0;
      acc.err   <= euc_pkg::ST_OK;
      acc.any   <= 1'b0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// File: hdl/euc_classify.sv
// ----------------------------------------------------------------------------
// euc_classify: end-of-text decision
// Turns the byte count and scan flags into status, kind and result fields
// in the order of precedence: length, pipe, vsock, empty, other.
// ----------------------------------------------------------------------------
module euc_classify #(
  parameter int unsigned MAX_TEXT_BYTES     = euc_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned PIPE_NAME_CAPACITY = euc_pkg::PIPE_NAME_CAPACITY_DEF,
  localparam int unsigned CNT_W             = $clog2(MAX_TEXT_BYTES + 2)
) (
  input  logic [CNT_W-1:0]     byte_count,
  input  euc_pkg::scan_flags_t flags,
  output euc_pkg::result_t     res
);

  logic [31:0] cnt;
  logic [31:0] name_len;

  assign cnt      = 32'(byte_count);
  assign name_len = cnt - 32'(euc_pkg::PIPE_TAG_LEN);

  always_comb begin
    res.status        = euc_pkg::ST_UNHANDLED;
    res.kind          = euc_pkg::KIND_NONE;
    res.cid           = '0;
    res.port          = '0;
    res.pipe_name_len = '0;
    if (cnt > 32'(MAX_TEXT_BYTES)) begin
      res.status = euc_pkg::ST_RANGE;
    end else if (cnt >= 32'(euc_pkg::PIPE_TAG_LEN) && flags.pipe_ok) begin
      if (name_len == 32'd0 || flags.name_bad) begin
        res.status = euc_pkg::ST_INVALID;
      end else if (name_len >= 32'(PIPE_NAME_CAPACITY)) begin
        res.status = euc_pkg::ST_RANGE;
      end else begin
        res.status        = euc_pkg::ST_OK;
        res.kind          = euc_pkg::KIND_PIPE;
        res.pipe_name_len = name_len[6:0];
      end
    end else if (cnt >= 32'(euc_pkg::VSOCK_TAG_LEN) && flags.vsock_ok) begin
      if (flags.colon_seen != 2'd1 || !flags.cid.any || !flags.port.any) begin
        res.status = euc_pkg::ST_INVALID;
      end else if (flags.cid.err != euc_pkg::ST_OK) begin
        res.status = flags.cid.err;
      end else if (flags.port.err != euc_pkg::ST_OK) begin
        res.status = flags.port.err;
      end else if (flags.cid.value == 32'hffff_ffff || flags.port.value == 32'hffff_ffff) begin
        res.status = euc_pkg::ST_INVALID;
      end else begin
        res.status = euc_pkg::ST_OK;
        res.kind   = euc_pkg::KIND_VSOCK;
        res.cid    = flags.cid.value;
        res.port   = flags.port.value;
      end
    end else if (cnt == 32'd0) begin
      res.status = euc_pkg::ST_INVALID;
    end
  end

endmodule

// File: hdl/endpoint_uri_classifier_core.sv
// ----------------------------------------------------------------------------
// endpoint_uri_classifier_core: streaming endpoint text classifier
// Result path: a terminator is captured in the input register, and the result
// register loads from the input register when the terminator advances.
// Throughput: one byte per cycle; the scan state update after the input
// register sets that figure. A terminator waits in the input register only
// while a previous result is stalled at the output.
// Reset: synchronous rst clears all scan state and both valid flags.
// ----------------------------------------------------------------------------
module endpoint_uri_classifier_core #(
  parameter int unsigned MAX_TEXT_BYTES     = euc_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned PIPE_NAME_CAPACITY = euc_pkg::PIPE_NAME_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [1:0]  kind,
  output logic [31:0] socket_cid,
  output logic [31:0] socket_port,
  output logic [6:0]  pipe_name_len
);

  localparam int unsigned CNT_W = $clog2(MAX_TEXT_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TEXT_BYTES);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // scan state
  logic [CNT_W-1:0]     byte_count;
  logic                 pipe_ok;
  logic                 vsock_ok;
  logic                 name_bad;
  logic [1:0]           colon_seen;
  euc_pkg::acc_state_t  cid_acc;
  euc_pkg::acc_state_t  port_acc;
  euc_pkg::scan_flags_t flags;
  euc_pkg::result_t     res_next;
  euc_pkg::result_t     res;

  logic advance;
  logic term;
  logic scan;
  logic in_body;
  logic take_cid;
  logic take_port;

  assign term    = (s1_byte == 8'd0);
  assign advance = s1_valid && (!term || !result_valid || !result_stall);
  assign text_stall = s1_valid && !advance;

  // a data byte is examined only while the count is within the limit
  assign scan    = advance && !term && (byte_count <= CNT_LIMIT);
  assign in_body = (byte_count >= CNT_W'(euc_pkg::VSOCK_TAG_LEN));
  assign take_cid  = scan && in_body && (s1_byte != euc_pkg::CHAR_COLON) && (colon_seen == 2'd0);
  assign take_port = scan && in_body && (s1_byte != euc_pkg::CHAR_COLON) && (colon_seen != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!text_stall) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall && text_valid) begin
      s1_byte <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && term)) begin
      byte_count <= '0;
      pipe_ok    <= 1'b1;
      vsock_ok   <= 1'b1;
      name_bad   <= 1'b0;
      colon_seen <= 2'd0;
    end else if (scan) begin
      if (byte_count < CNT_W'(euc_pkg::PIPE_TAG_LEN) &&
          s1_byte != euc_pkg::pipe_tag_char(byte_count[2:0])) begin
        pipe_ok <= 1'b0;
      end
      if (byte_count < CNT_W'(euc_pkg::VSOCK_TAG_LEN) &&
          s1_byte != euc_pkg::vsock_tag_char(byte_count[2:0])) begin
        vsock_ok <= 1'b0;
      end
      if (byte_count >= CNT_W'(euc_pkg::PIPE_TAG_LEN) && euc_pkg::bad_name_byte(s1_byte)) begin
        name_bad <= 1'b1;
      end
      if (in_body && s1_byte == euc_pkg::CHAR_COLON && colon_seen != 2'd2) begin
        colon_seen <= colon_seen + 2'd1;
      end
      byte_count <= byte_count + CNT_W'(1);
    end
  end

  euc_digit_acc u_cid (
    .clk       (clk),
    .rst       (rst),
    .clear     (advance && term),
    .take      (take_cid),
    .text_byte (s1_byte),
    .acc       (cid_acc)
  );

  euc_digit_acc u_port (
    .clk       (clk),
    .rst       (rst),
    .clear     (advance && term),
    .take      (take_port),
    .text_byte (s1_byte),
    .acc       (port_acc)
  );

  assign flags = {pipe_ok, vsock_ok, name_bad, colon_seen, cid_acc, port_acc};

  euc_classify #(
    .MAX_TEXT_BYTES     (MAX_TEXT_BYTES),
    .PIPE_NAME_CAPACITY (PIPE_NAME_CAPACITY)
  ) u_classify (
    .byte_count (byte_count),
    .flags      (flags),
    .res        (res_next)
  );

  // result register: load on terminator, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && term) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term) begin
      res <= res_next;
    end
  end

  assign status        = res.status;
  assign kind          = res.kind;
  assign socket_cid    = res.cid;
  assign socket_port   = res.port;
  assign pipe_name_len = res.pipe_name_len;

  a_stall_only_on_term: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (s1_valid && term && result_valid && result_stall))
    else $error("input stalled without a blocked terminator");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_LIMIT + CNT_W'(1))
    else $error("byte count past saturation");

  a_clear_after_term: assert property (@(posedge clk) disable iff (rst)
    (advance && term) |=> (byte_count == '0 && colon_seen == 2'd0 && result_valid))
    else $error("scan state not cleared after terminator");

  a_kind_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && res.kind != euc_pkg::KIND_NONE) |-> (res.status == euc_pkg::ST_OK))
    else $error("nonzero kind with failing status");

endmodule
